>>> hdl/spq_pkg.sv
package spq_pkg;

    localparam int QueueDepthDefault = 16;
    localparam int CountW = 5;
    localparam int ValueW = 32;
    localparam int PrioW = 8;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic opcode;
        logic signed [ValueW-1:0] item_value;
        logic [PrioW-1:0] item_priority;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic signed [ValueW-1:0] head_value;
        logic [PrioW-1:0] head_priority;
        logic is_empty;
        logic [CountW-1:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic load_req;
        logic do_push;
        logic do_pop;
        logic write_rsp;
        logic [1:0] rsp_code;
    } ctl_cmd_t;

    typedef struct packed {
        logic req_pop;
        logic full;
        logic empty;
    } dp_stat_t;

endpackage

>>> hdl/spq_ctrl.sv
module spq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  spq_pkg::dp_stat_t stat,
    output spq_pkg::ctl_cmd_t cmd,
    output logic              busy,
    output logic              done
);
    import spq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic done_reg;
    logic done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next = 1'b0;
        cmd = '0;
        cmd.rsp_code = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.write_rsp = 1'b1;
                done_next = 1'b1;
                state_next = S_IDLE;
                if (stat.req_pop)
                begin
                    if (stat.empty)
                    begin
                        cmd.rsp_code = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.do_pop = 1'b1;
                    end
                end
                else
                begin
                    if (stat.full)
                    begin
                        cmd.rsp_code = ST_FULL;
                    end
                    else
                    begin
                        cmd.do_push = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    assign busy = (state_reg == S_EXEC);
    assign done = done_reg;

    a_accept_execs: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && cmd.write_rsp))
        else $error("accepted request did not execute");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result strobe without a preceding execute cycle");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state is not one-hot");

endmodule

>>> hdl/spq_datapath.sv
module spq_datapath #(
    parameter int QUEUE_DEPTH = spq_pkg::QueueDepthDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  spq_pkg::req_t     request,
    input  spq_pkg::ctl_cmd_t cmd,
    output spq_pkg::dp_stat_t stat,
    output spq_pkg::rsp_t     result
);
    import spq_pkg::*;

    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    req_t req_reg;
    rsp_t rsp_reg;
    logic [PrioW-1:0] prio_reg [QUEUE_DEPTH];
    logic [PrioW-1:0] prio_next [QUEUE_DEPTH];
    logic [ValueW-1:0] val_reg [QUEUE_DEPTH];
    logic [ValueW-1:0] val_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] gt;
    logic [QUEUE_DEPTH-1:0] take;

    // Each held cell whose priority is strictly larger than the new one moves
    // back one place; the new entry lands in the first such cell or at the tail.
    always_comb
    begin
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            gt[k] = (CntW'(k) < count_reg) && (prio_reg[k] > req_reg.item_priority);
            take[k] = gt[k] || (CntW'(k) == count_reg);
        end
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            prio_next[k] = prio_reg[k];
            val_next[k] = val_reg[k];
            if (cmd.do_push && take[k])
            begin
                if (k > 0 && gt[(k > 0) ? k - 1 : 0])
                begin
                    prio_next[k] = prio_reg[(k > 0) ? k - 1 : 0];
                    val_next[k] = val_reg[(k > 0) ? k - 1 : 0];
                end
                else
                begin
                    prio_next[k] = req_reg.item_priority;
                    val_next[k] = req_reg.item_value;
                end
            end
            else if (cmd.do_pop && k < QUEUE_DEPTH - 1)
            begin
                prio_next[k] = prio_reg[(k < QUEUE_DEPTH - 1) ? k + 1 : k];
                val_next[k] = val_reg[(k < QUEUE_DEPTH - 1) ? k + 1 : k];
            end
        end
        count_next = count_reg;
        if (cmd.do_push)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (cmd.do_pop)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= request;
        end
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            prio_reg[k] <= prio_next[k];
            val_reg[k] <= val_next[k];
        end
        if (cmd.write_rsp)
        begin
            rsp_reg.status <= cmd.rsp_code;
            rsp_reg.head_value <= cmd.do_pop ? val_reg[0] : '0;
            rsp_reg.head_priority <= cmd.do_pop ? prio_reg[0] : '0;
            rsp_reg.is_empty <= (count_next == '0);
            rsp_reg.entry_count <= CountW'(count_next);
        end
    end

    assign stat.req_pop = (req_reg.opcode == OP_DEQUEUE);
    assign stat.full = (count_reg == CntW'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign result = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_pop |-> !stat.empty)
        else $error("pop issued on an empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_push |=> (count_reg == $past(count_reg) + CntW'(1)))
        else $error("push did not add one entry");

endmodule

>>> hdl/stable_priority_queue_unit.sv
// A request accepted while idle is executed in the next cycle and its result
// strobes on done for one cycle after that.
// The controller passes through its accept and execute states for each request
// and takes no new one while busy; every cell shifts in parallel, independent of depth.
// Reset: rst_n clears the entry count and the controller; no clearing pass.
// The receiver cannot stall, so done strobes for exactly one cycle per result; result holds until the next execute.
module stable_priority_queue_unit #(
    parameter int QUEUE_DEPTH = spq_pkg::QueueDepthDefault
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  spq_pkg::req_t request,
    output logic          busy,
    output logic          done,
    output spq_pkg::rsp_t result
);
    import spq_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    spq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

endmodule
